/* sv/mcw_pkg.sv */
// Package for the minimum covering window block: opcodes, sequencer states
// and default sizes. Used by minimum_covering_window; no dependencies.
package mcw_pkg;

  localparam int unsigned SYM_W          = 8;
  localparam int unsigned NUM_SYM        = 256;
  localparam int unsigned MAX_SOURCE_DEF = 4096;
  localparam int unsigned MAX_TARGET_DEF = 256;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_TARGET = 2'd1,
    OP_SOURCE = 2'd2,
    OP_FINISH = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TGT_UPD,
    S_SRC_UPD,
    S_CHECK,
    S_LEFT_RD,
    S_LEFT_UPD
  } state_e;

endpackage

/* sv/mcw_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mcw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, then register the read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/minimum_covering_window.sv */
// Minimum covering window: every item is taken in idle; a target item that fits
// then runs a need-table update, and a source item for a target byte runs a
// need-table update and a check, plus per left-edge advance a source-buffer read
// and, for a target byte, a need-table read-modify-write. Each byte is passed by
// the left edge at most once, and no new item is taken until the sequencer is idle.
// A finish result reaches the output register in the cycle after acceptance.
// Reset (and a clear item) empties the need table at once through per-byte
// valid flags; no clearing pass. Depends on mcw_pkg and mcw_ram.
module minimum_covering_window #(
  parameter int unsigned MAX_SOURCE = mcw_pkg::MAX_SOURCE_DEF,
  parameter int unsigned MAX_TARGET = mcw_pkg::MAX_TARGET_DEF,
  localparam int unsigned IDX_W     = $clog2(MAX_SOURCE),
  localparam int unsigned LEN_W     = $clog2(MAX_SOURCE + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       opcode_i,
  input  logic [7:0]       symbol_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             found_o,
  output logic [IDX_W-1:0] window_start_o,
  output logic [LEN_W-1:0] window_length_o,
  output logic             overflow_o
);

  localparam int unsigned SYM_W  = mcw_pkg::SYM_W;
  localparam int unsigned NSYM   = mcw_pkg::NUM_SYM;
  localparam int unsigned TGT_W  = $clog2(MAX_TARGET + 1);
  localparam int unsigned BIG    = (MAX_SOURCE > MAX_TARGET) ? MAX_SOURCE : MAX_TARGET;
  localparam int unsigned NEED_W = $clog2(BIG + 1) + 1;

  mcw_pkg::state_e state_q, state_d;

  logic [LEN_W-1:0] left_q, left_d, right_q, right_d;
  logic [TGT_W-1:0] matched_q, matched_d, tlen_q, tlen_d;
  logic             best_valid_q, best_valid_d;
  logic [LEN_W-1:0] best_len_q, best_len_d;
  logic [IDX_W-1:0] best_start_q, best_start_d;
  logic             ovf_q, ovf_d;
  logic [NSYM-1:0]  valid_q, valid_d;
  logic [SYM_W-1:0] sym_q, sym_d;

  logic             out_valid_q, out_valid_d;
  logic             out_found_q, out_found_d;
  logic [IDX_W-1:0] out_start_q, out_start_d;
  logic [LEN_W-1:0] out_len_q, out_len_d;
  logic             out_ovf_q, out_ovf_d;

  logic              tbl_we;
  logic [SYM_W-1:0]  tbl_raddr;
  logic [NEED_W-1:0] tbl_wdata, tbl_rdata, need_rd, need_new;
  logic              src_we;
  logic [SYM_W-1:0]  src_rdata;

  logic             accept;
  mcw_pkg::op_e     op;
  logic             tgt_go, src_go, src_hit, shrink, left_hit;
  logic [LEN_W-1:0] win_len;

  assign op       = mcw_pkg::op_e'(opcode_i);
  assign in_ready_o = (state_q == mcw_pkg::S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept   = in_valid_i && in_ready_o;

  assign tgt_go   = (right_q == '0) && (tlen_q < TGT_W'(MAX_TARGET));
  assign src_go   = right_q < LEN_W'(MAX_SOURCE);
  assign src_hit  = src_go && valid_q[symbol_i];
  assign shrink   = (tlen_q != '0) && (matched_q == tlen_q) && (left_q < right_q);
  assign left_hit = valid_q[src_rdata];
  assign win_len  = right_q - left_q;

  // An entry never written since the last clear reads as zero need
  assign need_rd  = valid_q[sym_q] ? tbl_rdata : '0;

  // Need counts per byte; a set valid flag also means the byte is in the target
  mcw_ram #(
    .WIDTH (NEED_W),
    .DEPTH (NSYM)
  ) u_need_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (sym_q),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // Source byte buffer
  mcw_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_SOURCE)
  ) u_src_ram (
    .clk_i   (clk_i),
    .we_i    (src_we),
    .waddr_i (right_q[IDX_W-1:0]),
    .wdata_i (symbol_i),
    .raddr_i (left_q[IDX_W-1:0]),
    .rdata_o (src_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mcw_pkg::S_IDLE: begin
        if (accept) begin
          if (op == mcw_pkg::OP_TARGET && tgt_go) begin
            state_d = mcw_pkg::S_TGT_UPD;
          end else if (op == mcw_pkg::OP_SOURCE && src_hit) begin
            state_d = mcw_pkg::S_SRC_UPD;
          end
        end
      end
      mcw_pkg::S_TGT_UPD:  state_d = mcw_pkg::S_IDLE;
      mcw_pkg::S_SRC_UPD:  state_d = mcw_pkg::S_CHECK;
      mcw_pkg::S_CHECK:    state_d = shrink ? mcw_pkg::S_LEFT_RD : mcw_pkg::S_IDLE;
      mcw_pkg::S_LEFT_RD:  state_d = left_hit ? mcw_pkg::S_LEFT_UPD : mcw_pkg::S_CHECK;
      mcw_pkg::S_LEFT_UPD: state_d = mcw_pkg::S_CHECK;
      default:             state_d = mcw_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    left_d       = left_q;
    right_d      = right_q;
    matched_d    = matched_q;
    tlen_d       = tlen_q;
    best_valid_d = best_valid_q;
    best_len_d   = best_len_q;
    best_start_d = best_start_q;
    ovf_d        = ovf_q;
    valid_d      = valid_q;
    sym_d        = sym_q;
    out_found_d  = out_found_q;
    out_start_d  = out_start_q;
    out_len_d    = out_len_q;
    out_ovf_d    = out_ovf_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    tbl_we       = 1'b0;
    tbl_raddr    = symbol_i;
    need_new     = need_rd;
    tbl_wdata    = need_new;
    src_we       = 1'b0;

    unique case (state_q)
      mcw_pkg::S_IDLE: begin
        if (accept) begin
          unique case (op)
            mcw_pkg::OP_CLEAR: begin
              valid_d      = '0;
              left_d       = '0;
              right_d      = '0;
              matched_d    = '0;
              tlen_d       = '0;
              best_valid_d = 1'b0;
              ovf_d        = 1'b0;
            end
            mcw_pkg::OP_TARGET: begin
              // Ignore target bytes once the source has started
              if (right_q == '0) begin
                if (tgt_go) begin
                  sym_d = symbol_i;
                end else begin
                  ovf_d = 1'b1;
                end
              end
            end
            mcw_pkg::OP_SOURCE: begin
              if (src_go) begin
                src_we  = 1'b1;
                right_d = right_q + LEN_W'(1);
                sym_d   = symbol_i;
              end else begin
                ovf_d = 1'b1;
              end
            end
            mcw_pkg::OP_FINISH: begin
              out_valid_d = 1'b1;
              out_found_d = (tlen_q != '0) && best_valid_q;
              out_start_d = out_found_d ? best_start_q : '0;
              out_len_d   = out_found_d ? best_len_q : '0;
              out_ovf_d   = ovf_q;
            end
            default: ;
          endcase
        end
      end
      mcw_pkg::S_TGT_UPD: begin
        need_new        = need_rd + NEED_W'(1);
        tbl_wdata       = need_new;
        tbl_we          = 1'b1;
        valid_d[sym_q]  = 1'b1;
        tlen_d          = tlen_q + TGT_W'(1);
      end
      mcw_pkg::S_SRC_UPD: begin
        need_new  = need_rd - NEED_W'(1);
        tbl_wdata = need_new;
        tbl_we    = 1'b1;
        if (!need_new[NEED_W-1]) begin
          matched_d = matched_q + TGT_W'(1);
        end
      end
      mcw_pkg::S_CHECK: begin
        // Record the window, then fetch the byte at the left edge
        if (shrink && (!best_valid_q || win_len < best_len_q)) begin
          best_valid_d = 1'b1;
          best_len_d   = win_len;
          best_start_d = left_q[IDX_W-1:0];
        end
      end
      mcw_pkg::S_LEFT_RD: begin
        tbl_raddr = src_rdata;
        sym_d     = src_rdata;
        if (!left_hit) begin
          left_d = left_q + LEN_W'(1);
        end
      end
      mcw_pkg::S_LEFT_UPD: begin
        need_new  = need_rd + NEED_W'(1);
        tbl_wdata = need_new;
        tbl_we    = 1'b1;
        if (!need_new[NEED_W-1] && need_new != '0) begin
          matched_d = matched_q - TGT_W'(1);
        end
        left_d = left_q + LEN_W'(1);
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mcw_pkg::S_IDLE;
      left_q       <= '0;
      right_q      <= '0;
      matched_q    <= '0;
      tlen_q       <= '0;
      best_valid_q <= 1'b0;
      ovf_q        <= 1'b0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      left_q       <= left_d;
      right_q      <= right_d;
      matched_q    <= matched_d;
      tlen_q       <= tlen_d;
      best_valid_q <= best_valid_d;
      ovf_q        <= ovf_d;
      valid_q      <= valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    best_len_q   <= best_len_d;
    best_start_q <= best_start_d;
    sym_q        <= sym_d;
    out_found_q  <= out_found_d;
    out_start_q  <= out_start_d;
    out_len_q    <= out_len_d;
    out_ovf_q    <= out_ovf_d;
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = out_found_q;
  assign window_start_o  = out_start_q;
  assign window_length_o = out_len_q;
  assign overflow_o      = out_ovf_q;

`ifndef ASSERT_OFF
  a_matched_le_tlen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    matched_q <= tlen_q)
    else $error("matched count exceeds target length");

  a_left_le_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= right_q)
    else $error("left edge passed right edge");

  a_finish_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == mcw_pkg::OP_FINISH) |=> out_valid_q)
    else $error("finish item gave no result");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != mcw_pkg::S_IDLE) |-> !accept)
    else $error("item accepted while sequencer busy");
`endif

endmodule
